/* rtl/motor_mode_switch_controller_assert.svh */
// assertion macros for the motor mode switch controller
`ifndef MOTOR_MODE_SWITCH_CONTROLLER_ASSERT_SVH
`define MOTOR_MODE_SWITCH_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
// condition must hold at every clock edge out of reset
`define MMSC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent at one edge implies consequent at the next
`define MMSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MMSC_ASSERT_ALWAYS(lbl, cond, msg)
`define MMSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/mmsc_pkg.sv */
// shared types and codes for the motor mode switch controller
`default_nettype none

package mmsc_pkg;

  // request types
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_SET_A = 2'd1;
  localparam logic [1:0] REQ_SET_B = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  // response codes
  localparam logic [2:0] RSP_NONE  = 3'd0;
  localparam logic [2:0] RSP_ACK   = 3'd1;
  localparam logic [2:0] RSP_NAK   = 3'd2;
  localparam logic [2:0] RSP_QUERY = 3'd3;
  localparam logic [2:0] RSP_BUSY  = 3'd4;

  // motor drive codes
  localparam logic [1:0] DRV_BRAKE = 2'd0;
  localparam logic [1:0] DRV_FWD   = 2'd1;
  localparam logic [1:0] DRV_REV   = 2'd2;

  // mode codes
  localparam logic [1:0] MODE_UNKNOWN = 2'd0;
  localparam logic [1:0] MODE_A       = 2'd1;
  localparam logic [1:0] MODE_B       = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_HIGH_RUN_LIMIT    = 3'd0;
  localparam logic [2:0] CFG_STABLE_LOW_COUNT  = 3'd1;
  localparam logic [2:0] CFG_TOTAL_TICK_LIMIT  = 3'd2;
  localparam logic [2:0] CFG_START_DELAY_TICKS = 3'd3;
  localparam logic [2:0] CFG_SETTLE_TICKS      = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [15:0] high_run_limit;
    logic [7:0]  stable_low_count;
    logic [15:0] total_tick_limit;
    logic [15:0] start_delay_ticks;
    logic [15:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic [15:0] tag;
    logic        sensor;
    logic [1:0]  req_type;
  } item_t;

  typedef struct packed {
    logic        busy_res;
    logic        seen_high;
    logic        sensor_now;
    logic [1:0]  mode_now;
    logic [1:0]  motor_drive;
    logic [15:0] reply_tag;
    logic [2:0]  response;
  } result_t;

endpackage

`default_nettype wire

/* rtl/mmsc_in_reg.sv */
// input register stage for request items
`default_nettype none

module mmsc_in_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mmsc_pkg::item_t in_item,
  input  wire logic           adv,
  output logic                item_vld,
  output mmsc_pkg::item_t     item
);

  logic            vld_r;
  logic            vld_nxt;
  mmsc_pkg::item_t item_r;

  // free when empty or when the held item moves on this cycle
  assign in_ready = !vld_r || adv;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

`default_nettype wire

/* rtl/mmsc_step.sv */
// switch sequencer state and single-pass next-state logic
`default_nettype none

`include "motor_mode_switch_controller_assert.svh"

module mmsc_step #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire mmsc_pkg::item_t item,
  input  wire mmsc_pkg::cfg_t  cfg,
  output mmsc_pkg::result_t    res
);

  localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_SAMPLE,
    PH_SETTLE
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic                  target_b_r, target_b_nxt;
  logic [1:0]            mode_r, mode_nxt;
  logic                  seen_r, seen_nxt;
  logic                  init_lvl_r, init_lvl_nxt;
  logic [7:0]            low_run_r, low_run_nxt;
  logic [COUNT_BITS-1:0] high_run_r, high_run_nxt;
  logic [COUNT_BITS-1:0] tick_tot_r, tick_tot_nxt;
  logic [COUNT_BITS-1:0] delay_r, delay_nxt;
  logic [15:0]           pend_tag_r, pend_tag_nxt;
  logic [1:0]            drive_r, drive_nxt;

  logic                  do_sample;
  logic                  do_finish;
  logic                  do_fail;
  logic [2:0]            rsp;
  logic [15:0]           rtag;

  // next state for one request
  always_comb begin
    phase_nxt    = phase_r;
    target_b_nxt = target_b_r;
    mode_nxt     = mode_r;
    seen_nxt     = seen_r;
    init_lvl_nxt = init_lvl_r;
    low_run_nxt  = low_run_r;
    high_run_nxt = high_run_r;
    tick_tot_nxt = tick_tot_r;
    delay_nxt    = delay_r;
    pend_tag_nxt = pend_tag_r;
    drive_nxt    = drive_r;
    do_sample    = 1'b0;
    do_finish    = 1'b0;
    do_fail      = 1'b0;
    rsp          = mmsc_pkg::RSP_NONE;
    rtag         = '0;

    unique case (item.req_type)
      mmsc_pkg::REQ_TICK: begin
        // delays count down; the tick that finds zero moves on
        case (phase_r)
          PH_START: begin
            if (delay_r != '0) begin
              delay_nxt = delay_r - 1'b1;
            end else begin
              phase_nxt = PH_SAMPLE;
              do_sample = 1'b1;
            end
          end
          PH_SETTLE: begin
            if (delay_r != '0) begin
              delay_nxt = delay_r - 1'b1;
            end else begin
              do_finish = 1'b1;
            end
          end
          PH_SAMPLE: do_sample = 1'b1;
          default: ;
        endcase

        // feedback sampling
        if (do_sample) begin
          tick_tot_nxt = (tick_tot_r != CNT_MAX) ? tick_tot_r + 1'b1 : CNT_MAX;
          if (item.sensor) begin
            seen_nxt     = 1'b1;
            low_run_nxt  = '0;
            high_run_nxt = (high_run_r != CNT_MAX) ? high_run_r + 1'b1 : CNT_MAX;
            if (CW'(high_run_nxt) > CW'(cfg.high_run_limit)) begin
              do_fail = 1'b1;
            end else if (CW'(tick_tot_nxt) > CW'(cfg.total_tick_limit)) begin
              do_fail = 1'b1;
            end
          end else begin
            low_run_nxt = (low_run_r != 8'hff) ? low_run_r + 1'b1 : 8'hff;
            if (low_run_nxt >= cfg.stable_low_count) begin
              // end point reached
              if (init_lvl_r) begin
                seen_nxt = 1'b1;
              end
              phase_nxt = PH_SETTLE;
              delay_nxt = COUNT_BITS'(cfg.settle_ticks);
              if (COUNT_BITS'(cfg.settle_ticks) == '0) begin
                do_finish = 1'b1;
              end
            end else if (CW'(tick_tot_nxt) > CW'(cfg.total_tick_limit)) begin
              do_fail = 1'b1;
            end
          end
        end

        // end of a switch
        if (do_fail) begin
          drive_nxt = mmsc_pkg::DRV_BRAKE;
          mode_nxt  = mmsc_pkg::MODE_UNKNOWN;
          phase_nxt = PH_IDLE;
          rsp       = mmsc_pkg::RSP_NAK;
        end else if (do_finish) begin
          drive_nxt = mmsc_pkg::DRV_BRAKE;
          phase_nxt = PH_IDLE;
          if (seen_nxt) begin
            mode_nxt = target_b_r ? mmsc_pkg::MODE_B : mmsc_pkg::MODE_A;
            rsp      = mmsc_pkg::RSP_ACK;
          end else begin
            mode_nxt = mmsc_pkg::MODE_UNKNOWN;
            rsp      = mmsc_pkg::RSP_NAK;
          end
        end
        if (rsp != mmsc_pkg::RSP_NONE) begin
          rtag = pend_tag_r;
        end
      end

      mmsc_pkg::REQ_QUERY: begin
        rsp  = mmsc_pkg::RSP_QUERY;
        rtag = item.tag;
      end

      mmsc_pkg::REQ_SET_A, mmsc_pkg::REQ_SET_B: begin
        if (phase_r != PH_IDLE) begin
          rsp  = mmsc_pkg::RSP_BUSY;
          rtag = item.tag;
        end else begin
          seen_nxt = 1'b0;
          if (item.req_type == mode_r && !item.sensor) begin
            // already there
            rsp  = mmsc_pkg::RSP_ACK;
            rtag = item.tag;
          end else begin
            // start the motor toward the target
            pend_tag_nxt = item.tag;
            target_b_nxt = (item.req_type == mmsc_pkg::REQ_SET_B);
            init_lvl_nxt = item.sensor;
            drive_nxt    = (item.req_type == mmsc_pkg::REQ_SET_B) ?
                           mmsc_pkg::DRV_FWD : mmsc_pkg::DRV_REV;
            phase_nxt    = PH_START;
            delay_nxt    = COUNT_BITS'(cfg.start_delay_ticks);
            low_run_nxt  = '0;
            high_run_nxt = '0;
            tick_tot_nxt = '0;
          end
        end
      end

      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      target_b_r <= 1'b0;
      mode_r     <= mmsc_pkg::MODE_UNKNOWN;
      seen_r     <= 1'b0;
      init_lvl_r <= 1'b0;
      low_run_r  <= '0;
      high_run_r <= '0;
      tick_tot_r <= '0;
      delay_r    <= '0;
      pend_tag_r <= '0;
      drive_r    <= mmsc_pkg::DRV_BRAKE;
    end else if (adv) begin
      phase_r    <= phase_nxt;
      target_b_r <= target_b_nxt;
      mode_r     <= mode_nxt;
      seen_r     <= seen_nxt;
      init_lvl_r <= init_lvl_nxt;
      low_run_r  <= low_run_nxt;
      high_run_r <= high_run_nxt;
      tick_tot_r <= tick_tot_nxt;
      delay_r    <= delay_nxt;
      pend_tag_r <= pend_tag_nxt;
      drive_r    <= drive_nxt;
    end
  end

  // result fields reflect the state after this request
  always_comb begin
    res.response    = rsp;
    res.reply_tag   = rtag;
    res.motor_drive = drive_nxt;
    res.mode_now    = mode_nxt;
    res.sensor_now  = item.sensor;
    res.seen_high   = seen_nxt;
    res.busy_res    = (phase_nxt != PH_IDLE);
  end

  // motor runs exactly while a switch is in progress
  `MMSC_ASSERT_ALWAYS(a_drive_busy, (phase_r == PH_IDLE) == (drive_r == mmsc_pkg::DRV_BRAKE), "drive/phase mismatch")
  // sampling starts only after the start delay ran out
  `MMSC_ASSERT_ALWAYS(a_sample_delay, (phase_r != PH_SAMPLE) || (delay_r == '0), "delay left while sampling")
  // mode only changes when a request is processed
  `MMSC_ASSERT_NEXT(a_mode_hold, !adv, $stable(mode_r), "mode changed without a request")
  // a started switch is busy afterwards
  `MMSC_ASSERT_NEXT(a_start_busy, adv && (phase_r == PH_IDLE) && (phase_nxt == PH_START), phase_r == PH_START, "switch did not start")

endmodule

`default_nettype wire

/* rtl/mmsc_out_reg.sv */
// result register toward the output channel
`default_nettype none

module mmsc_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire mmsc_pkg::result_t res,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output mmsc_pkg::result_t      out_res
);

  logic              vld_r;
  logic              vld_nxt;
  mmsc_pkg::result_t res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

/* rtl/motor_mode_switch_controller.sv */
// top level of the motor mode switch controller
//
// channel  dir  handshake                 payload
// in_      in   in_tvalid / in_tready     in_tdata: request item
// out_     out  out_tvalid / out_tready   out_tdata: one response per request
// cfg_     in   cfg_we                    cfg_idx, cfg_wdata: limit registers
//
// one request per cycle sustained while out_tready holds high; a request passes the input
// register, then the sequencer step into the result register, and out_tvalid rises when
// the result register loads, so a stalled output can hold it in the input register
// the sequencer state updates in the same cycle the result register loads
// a stalled output holds both registers; the input side keeps taking a request
// while its register is empty; rst_n is synchronous and restores reset limits
`default_nettype none

module motor_mode_switch_controller #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // req_type[1:0], sensor[2], tag[18:3], zero fill [23:19]
  input  wire logic [23:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // response[2:0], reply_tag[18:3], motor_drive[20:19], mode_now[22:21],
  // sensor_now[23], seen_high[24], busy_res[25], zero fill [31:26]
  output logic [31:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [mmsc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [mmsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mmsc_pkg::cfg_t    cfg_r;
  mmsc_pkg::item_t   in_item;
  mmsc_pkg::item_t   item;
  mmsc_pkg::result_t res;
  mmsc_pkg::result_t out_res;
  logic              item_vld;
  logic              adv;

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_run_limit    <= 16'd300;
      cfg_r.stable_low_count  <= 8'd5;
      cfg_r.total_tick_limit  <= 16'd500;
      cfg_r.start_delay_ticks <= 16'd10;
      cfg_r.settle_ticks      <= 16'd10;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        mmsc_pkg::CFG_HIGH_RUN_LIMIT:    cfg_r.high_run_limit    <= cfg_wdata;
        mmsc_pkg::CFG_STABLE_LOW_COUNT:  cfg_r.stable_low_count  <= cfg_wdata[7:0];
        mmsc_pkg::CFG_TOTAL_TICK_LIMIT:  cfg_r.total_tick_limit  <= cfg_wdata;
        mmsc_pkg::CFG_START_DELAY_TICKS: cfg_r.start_delay_ticks <= cfg_wdata;
        mmsc_pkg::CFG_SETTLE_TICKS:      cfg_r.settle_ticks      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // unpack the request
  assign in_item.req_type = in_tdata[1:0];
  assign in_item.sensor   = in_tdata[2];
  assign in_item.tag      = in_tdata[18:3];

  // a held request moves on when the result register is empty or being read
  assign adv = item_vld && (!out_tvalid || out_tready);

  mmsc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .adv      (adv),
    .item_vld (item_vld),
    .item     (item)
  );

  mmsc_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item),
    .cfg   (cfg_r),
    .res   (res)
  );

  mmsc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res       (res),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (out_res)
  );

  // pack the response
  assign out_tdata = {6'b0, out_res.busy_res, out_res.seen_high, out_res.sensor_now,
                      out_res.mode_now, out_res.motor_drive, out_res.reply_tag,
                      out_res.response};

endmodule

`default_nettype wire

/* tb/mmsc_checker.sv */
// reply predictor and scoreboard for the motor mode switch controller
`timescale 1ns / 1ps

module mmsc_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [23:0]                     in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [31:0]                     out_tdata,
  input  logic                            cfg_we,
  input  logic [mmsc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [mmsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              replies_owed
);

  typedef enum logic [1:0] {PH_IDLE, PH_START, PH_SAMPLE, PH_SETTLE} sweep_phase_t;

  localparam logic [15:0] COUNT_TOP = 16'hFFFF;
  localparam logic [7:0]  LOW_TOP   = 8'hFF;

  // limit registers as the block should hold them
  logic [15:0] lim_high;
  logic [7:0]  lim_low;
  logic [15:0] lim_total;
  logic [15:0] dly_start;
  logic [15:0] dly_settle;

  // switch sequencer state
  sweep_phase_t phase;
  logic        tgt_b;
  logic [1:0]  mode;
  logic        seen;
  logic        init_lvl;
  logic [7:0]  low_cnt;
  logic [15:0] high_cnt;
  logic [15:0] tick_cnt;
  logic [15:0] dly;
  logic [15:0] owner_tag;
  logic [1:0]  drive;

  mmsc_pkg::result_t pending_replies[$];

  initial begin
    fail_count   = 0;
    replies_owed = 0;
  end

  // brake and leave the switch; success needs the end point and a high pin seen
  function automatic logic [2:0] stop_motor(input logic reached);
    drive = mmsc_pkg::DRV_BRAKE;
    phase = PH_IDLE;
    if (reached && seen) begin
      mode = tgt_b ? mmsc_pkg::MODE_B : mmsc_pkg::MODE_A;
      return mmsc_pkg::RSP_ACK;
    end
    mode = mmsc_pkg::MODE_UNKNOWN;
    return mmsc_pkg::RSP_NAK;
  endfunction

  // one tick of the sequencer
  function automatic logic [2:0] advance_tick(input logic s);
    if (phase == PH_START) begin
      if (dly != 0) begin
        dly = dly - 1'b1;
        return mmsc_pkg::RSP_NONE;
      end
      phase = PH_SAMPLE;
    end else if (phase == PH_SETTLE) begin
      if (dly != 0) begin
        dly = dly - 1'b1;
        return mmsc_pkg::RSP_NONE;
      end
      return stop_motor(1'b1);
    end
    if (phase != PH_SAMPLE) return mmsc_pkg::RSP_NONE;

    if (tick_cnt != COUNT_TOP) tick_cnt = tick_cnt + 1'b1;
    if (s) begin
      seen    = 1'b1;
      low_cnt = '0;
      if (high_cnt != COUNT_TOP) high_cnt = high_cnt + 1'b1;
      if (high_cnt > lim_high) return stop_motor(1'b0);
    end else begin
      if (low_cnt != LOW_TOP) low_cnt = low_cnt + 1'b1;
      if (low_cnt >= lim_low) begin
        // end point reached; a pin that started high counts as seen
        if (init_lvl) seen = 1'b1;
        phase = PH_SETTLE;
        dly   = dly_settle;
        if (dly == 0) return stop_motor(1'b1);
        return mmsc_pkg::RSP_NONE;
      end
    end
    if (tick_cnt > lim_total) return stop_motor(1'b0);
    return mmsc_pkg::RSP_NONE;
  endfunction

  // expected reply to one request
  function automatic mmsc_pkg::result_t predict_reply(input mmsc_pkg::item_t it);
    mmsc_pkg::result_t r;
    logic [2:0] rsp;
    logic [15:0] rtag;
    logic [1:0] want_mode;
    rsp  = mmsc_pkg::RSP_NONE;
    rtag = '0;
    case (it.req_type)
      mmsc_pkg::REQ_TICK: begin
        rsp = advance_tick(it.sensor);
        if (rsp != mmsc_pkg::RSP_NONE) rtag = owner_tag;
      end
      mmsc_pkg::REQ_QUERY: begin
        rsp  = mmsc_pkg::RSP_QUERY;
        rtag = it.tag;
      end
      default: begin
        want_mode = (it.req_type == mmsc_pkg::REQ_SET_B) ? mmsc_pkg::MODE_B : mmsc_pkg::MODE_A;
        if (phase != PH_IDLE) begin
          rsp  = mmsc_pkg::RSP_BUSY;
          rtag = it.tag;
        end else if (want_mode == mode && !it.sensor) begin
          seen = 1'b0;
          rsp  = mmsc_pkg::RSP_ACK;
          rtag = it.tag;
        end else begin
          // start a new switch, reply comes when it ends
          seen      = 1'b0;
          owner_tag = it.tag;
          tgt_b     = (it.req_type == mmsc_pkg::REQ_SET_B);
          init_lvl  = it.sensor;
          drive     = tgt_b ? mmsc_pkg::DRV_FWD : mmsc_pkg::DRV_REV;
          phase     = PH_START;
          dly       = dly_start;
          low_cnt   = '0;
          high_cnt  = '0;
          tick_cnt  = '0;
        end
      end
    endcase
    r.response    = rsp;
    r.reply_tag   = rtag;
    r.motor_drive = drive;
    r.mode_now    = mode;
    r.sensor_now  = it.sensor;
    r.seen_high   = seen;
    r.busy_res    = (phase != PH_IDLE);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // watch requests, replies and register writes at each rising edge
  always @(posedge clk) begin : watch
    mmsc_pkg::result_t got;
    mmsc_pkg::result_t want;
    if (!rst_n) begin
      lim_high   = 16'd300;
      lim_low    = 8'd5;
      lim_total  = 16'd500;
      dly_start  = 16'd10;
      dly_settle = 16'd10;
      phase      = PH_IDLE;
      tgt_b      = 1'b0;
      mode       = mmsc_pkg::MODE_UNKNOWN;
      seen       = 1'b0;
      init_lvl   = 1'b0;
      low_cnt    = '0;
      high_cnt   = '0;
      tick_cnt   = '0;
      dly        = '0;
      owner_tag  = '0;
      drive      = mmsc_pkg::DRV_BRAKE;
      pending_replies.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = mmsc_pkg::result_t'(out_tdata[$bits(mmsc_pkg::result_t)-1:0]);
        if (pending_replies.size() == 0) begin
          $error("reply with nothing outstanding: %h", out_tdata);
          fail_count++;
        end else begin
          want = pending_replies.pop_front();
          check_field("response", 16'(want.response), 16'(got.response));
          check_field("reply_tag", want.reply_tag, got.reply_tag);
          check_field("motor_drive", 16'(want.motor_drive), 16'(got.motor_drive));
          check_field("mode_now", 16'(want.mode_now), 16'(got.mode_now));
          check_field("sensor_now", 16'(want.sensor_now), 16'(got.sensor_now));
          check_field("seen_high", 16'(want.seen_high), 16'(got.seen_high));
          check_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
        end
      end
      if (in_tvalid && in_tready)
        pending_replies.push_back(
          predict_reply(mmsc_pkg::item_t'(in_tdata[$bits(mmsc_pkg::item_t)-1:0])));
      if (cfg_we) begin
        case (cfg_idx)
          mmsc_pkg::CFG_HIGH_RUN_LIMIT:    lim_high   = cfg_wdata;
          mmsc_pkg::CFG_STABLE_LOW_COUNT:  lim_low    = cfg_wdata[7:0];
          mmsc_pkg::CFG_TOTAL_TICK_LIMIT:  lim_total  = cfg_wdata;
          mmsc_pkg::CFG_START_DELAY_TICKS: dly_start  = cfg_wdata;
          mmsc_pkg::CFG_SETTLE_TICKS:      dly_settle = cfg_wdata;
          default: ;
        endcase
      end
    end
    replies_owed = pending_replies.size();
  end

endmodule

/* tb/tb_top.sv */
// stimulus and verdict for the motor mode switch controller
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT = 2000;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  // req_type[1:0], sensor[2], tag[18:3], zero fill [23:19]
  logic [23:0]                     in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  // response[2:0], reply_tag[18:3], motor_drive[20:19], mode_now[22:21],
  // sensor_now[23], seen_high[24], busy_res[25], zero fill [31:26]
  logic [31:0]                     out_tdata;
  logic                            cfg_we;
  logic [mmsc_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [mmsc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int replies_owed;
  int send_idle_pct;
  int recv_idle_pct;
  int stalled_cycles;
  bit noise_on;
  logic last_busy;
  mmsc_pkg::result_t out_fields;

  // limits as last written, used to shape the tick runs
  int unsigned cfg_high;
  int unsigned cfg_low;
  int unsigned cfg_total;
  int unsigned cfg_start;
  int unsigned cfg_settle;

  motor_mode_switch_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  mmsc_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .replies_owed (replies_owed)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver stalls
  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // busy flag of the latest reply, tells when a switch has ended
  assign out_fields = mmsc_pkg::result_t'(out_tdata[$bits(mmsc_pkg::result_t)-1:0]);
  always @(posedge clk) begin
    if (!rst_n) last_busy <= 1'b0;
    else if (out_tvalid && out_tready) last_busy <= out_fields.busy_res;
  end

  // watchdog on cycles without any request or reply moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles == STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // one request, with random sender gaps; called and left at a falling edge
  task automatic send_item(input logic [1:0] req, input logic s, input logic [15:0] tag);
    mmsc_pkg::item_t it;
    it.req_type = req;
    it.sensor   = s;
    it.tag      = tag;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(24 - $bits(mmsc_pkg::item_t)){1'b0}}, it};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // tick with occasional queries, stray set-mode requests and pin glitches
  task automatic send_tick(input logic s);
    int pick;
    pick = $urandom_range(99);
    if (noise_on && pick < 4)
      send_item(mmsc_pkg::REQ_QUERY, 1'($urandom_range(1)), 16'($urandom));
    else if (noise_on && pick < 7)
      send_item(pick[0] ? mmsc_pkg::REQ_SET_A : mmsc_pkg::REQ_SET_B, 1'($urandom_range(1)),
                16'($urandom));
    if (noise_on && $urandom_range(19) == 0) s = ~s;
    send_item(mmsc_pkg::REQ_TICK, s, 16'($urandom));
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (replies_owed != 0);
  endtask

  // low ticks until no switch is running
  task automatic finish_switching();
    drain_replies();
    while (last_busy) begin
      send_item(mmsc_pkg::REQ_TICK, 1'b0, 16'($urandom));
      drain_replies();
    end
  endtask

  task automatic write_reg(input logic [mmsc_pkg::CFG_IDX_W-1:0] idx, input int unsigned v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v[mmsc_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
  endtask

  // write all limits once the block is quiet
  task automatic apply_config(input int unsigned h, input int unsigned l, input int unsigned t,
                              input int unsigned s, input int unsigned st);
    finish_switching();
    repeat (4) @(negedge clk);
    write_reg(mmsc_pkg::CFG_HIGH_RUN_LIMIT, h);
    write_reg(mmsc_pkg::CFG_STABLE_LOW_COUNT, l);
    write_reg(mmsc_pkg::CFG_TOTAL_TICK_LIMIT, t);
    write_reg(mmsc_pkg::CFG_START_DELAY_TICKS, s);
    write_reg(mmsc_pkg::CFG_SETTLE_TICKS, st);
    cfg_we     <= 1'b0;
    cfg_high   = h;
    cfg_low    = l & 8'hFF;
    cfg_total  = t;
    cfg_start  = s;
    cfg_settle = st;
  endtask

  // set-mode request followed by a start delay, a high run and a low run
  task automatic run_switch(input bit force_start);
    int unsigned cap;
    int unsigned highs;
    int unsigned pick;
    int unsigned n;
    send_item($urandom_range(1) ? mmsc_pkg::REQ_SET_B : mmsc_pkg::REQ_SET_A,
              force_start ? 1'b1 : ($urandom_range(3) == 0), 16'($urandom));
    for (n = 0; n < cfg_start; n++) send_tick(1'($urandom_range(1)));
    for (n = $urandom_range(4); n > 0; n--) send_tick(1'b0);
    cap  = (cfg_high < 40) ? cfg_high : 40;
    pick = $urandom_range(3);
    if (pick == 0) highs = 0;
    else if (pick < 3) highs = $urandom_range((cap > 0) ? cap : 1, 1);
    else highs = cap + 1;
    for (n = 0; n < highs; n++) send_tick(1'b1);
    for (n = 0; n < cfg_low + cfg_settle + 2; n++) send_tick(1'b0);
  endtask

  task automatic set_pace(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    int stage;
    int k;
    int n;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    stalled_cycles = 0;
    noise_on       = 1'b1;
    cfg_high       = 300;
    cfg_low        = 5;
    cfg_total      = 500;
    cfg_start      = 10;
    cfg_settle     = 10;
    set_pace(6, 74);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: queries, idle ticks, busy rejects, quick ack, ack, nak
    send_item(mmsc_pkg::REQ_QUERY, 1'b0, 16'h0000);
    send_item(mmsc_pkg::REQ_QUERY, 1'b1, 16'hFFFF);
    send_item(mmsc_pkg::REQ_TICK, 1'b1, 16'hFFFF);
    send_item(mmsc_pkg::REQ_TICK, 1'b0, 16'h0000);
    send_item(mmsc_pkg::REQ_SET_A, 1'b1, 16'h1234);
    send_item(mmsc_pkg::REQ_SET_B, 1'b0, 16'hFFFF);
    send_item(mmsc_pkg::REQ_SET_A, 1'b1, 16'h0000);
    send_item(mmsc_pkg::REQ_QUERY, 1'b1, 16'h00FF);
    finish_switching();
    send_item(mmsc_pkg::REQ_SET_A, 1'b0, 16'hA5A5);
    send_item(mmsc_pkg::REQ_SET_A, 1'b1, 16'h5A5A);
    finish_switching();
    send_item(mmsc_pkg::REQ_SET_B, 1'b0, 16'h8001);
    finish_switching();
    send_item(mmsc_pkg::REQ_SET_B, 1'b0, 16'h7FFE);
    for (n = 0; n < 10; n++)
      send_item(mmsc_pkg::REQ_TICK, 1'($urandom_range(1)), 16'($urandom));
    for (n = 0; n < 3; n++) send_item(mmsc_pkg::REQ_TICK, 1'b1, 16'($urandom));
    finish_switching();

    // random switches, reset limits first
    repeat (4) run_switch(1'b0);

    // random switches under several limit settings and idle patterns
    for (stage = 0; stage < 3; stage++) begin
      if (stage == 0) set_pace(6, 74);
      else if (stage == 1) set_pace(74, 6);
      else set_pace(0, 0);
      for (k = 0; k < 3; k++) begin
        if (stage == 0 && k == 0)
          apply_config(0, 0, 0, 0, 0);
        else
          apply_config(($urandom_range(3) == 0) ? 65535 : $urandom_range(12),
                       $urandom_range(6),
                       ($urandom_range(3) == 0) ? 65535 : $urandom_range(60),
                       $urandom_range(6), $urandom_range(6));
        repeat (4) run_switch(1'b0);
      end
    end

    // largest limits and end-point count, one clean switch
    noise_on = 1'b0;
    apply_config(65535, 255, 65535, 0, 0);
    run_switch(1'b1);

    finish_switching();
    repeat (8) @(negedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
